// ===== design/binary_to_decimal_ascii_core_assert.svh =====
// Assertion macros for the decimal conversion core.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/b2da_pkg.sv =====
`default_nettype none

package b2da_pkg;

  localparam int VALUE_W = 32;
  localparam int PROD_W = 64;
  localparam int QUO_SHIFT = 35;
  localparam int QUO_W = PROD_W - QUO_SHIFT;
  localparam int CHAR_W = 6;
  localparam int DIGIT_W = 4;
  localparam int MAX_DIGITS = 10;
  localparam int CNT_W = 4;

  // floor(n / 10) == (n * RECIP_TEN) >> 35 for every 32-bit n
  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [1:0] step_t;
  typedef logic [1:0] cond_t;

  localparam step_t STEP_IDLE = 2'd0;
  localparam step_t STEP_DIV = 2'd1;
  localparam step_t STEP_EMIT = 2'd2;
  localparam step_t STEP_SPARE = 2'd3;

  localparam cond_t COND_NONE = 2'd0;
  localparam cond_t COND_START = 2'd1;
  localparam cond_t COND_QZERO = 2'd2;
  localparam cond_t COND_LAST = 2'd3;

  typedef struct packed {
    logic  busy;
    logic  load;
    logic  div;
    logic  emit;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctl_t;

  // microcode: wait/load, divide loop, emit loop
  function automatic ctl_t ctl_rom(input step_t pc);
    ctl_t w;
    w = '0;
    case (pc)
      STEP_IDLE: begin
        w.load  = 1'b1;
        w.cond  = COND_START;
        w.tgt_t = STEP_DIV;
        w.tgt_f = STEP_IDLE;
      end
      STEP_DIV: begin
        w.busy  = 1'b1;
        w.div   = 1'b1;
        w.cond  = COND_QZERO;
        w.tgt_t = STEP_EMIT;
        w.tgt_f = STEP_DIV;
      end
      STEP_EMIT: begin
        w.busy  = 1'b1;
        w.emit  = 1'b1;
        w.cond  = COND_LAST;
        w.tgt_t = STEP_IDLE;
        w.tgt_f = STEP_EMIT;
      end
      default: begin
        w.busy  = 1'b1;
        w.cond  = COND_NONE;
        w.tgt_t = STEP_IDLE;
        w.tgt_f = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/binary_to_decimal_ascii_core.sv =====
// channel   | ports                         | handshake
// ----------+-------------------------------+------------------------------
// request   | value[31:0]                   | start high while busy low
// result    | digit_char[5:0], last         | digit_valid, one cycle, no stall
//
// A number with 1..10 decimal digits is taken in its load cycle, then runs
// divide-by-ten through the reciprocal multiplier (one digit per cycle), then
// emit steps reading the digit buffer most significant first, each digit leaving
// through the output register. busy is low while the last digit is shown, so
// the next request can already be taken while that digit is on the output.
// Synchronous reset returns the sequencer to idle and drops digit_valid.
// The receiver cannot stall; a new request is taken as soon as busy falls.
`default_nettype none

module binary_to_decimal_ascii_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [b2da_pkg::VALUE_W-1:0]    value,
  output logic                                 busy,
  output logic                                 digit_valid,
  output logic      [b2da_pkg::CHAR_W-1:0]     digit_char,
  output logic                                 last
);

`include "binary_to_decimal_ascii_core_assert.svh"

  b2da_pkg::step_t pc;
  b2da_pkg::step_t pc_next;
  b2da_pkg::ctl_t  ctl;
  logic            cond_hit;
  logic            load_go;

  logic [b2da_pkg::CNT_W-1:0]   cnt;
  logic [b2da_pkg::QUO_W-1:0]   quo;
  logic [b2da_pkg::DIGIT_W-1:0] dividend;
  logic [b2da_pkg::VALUE_W-1:0] mult_a;
  logic [b2da_pkg::PROD_W-1:0]  product;
  logic [b2da_pkg::DIGIT_W-1:0] ten_q;
  logic [b2da_pkg::DIGIT_W-1:0] rem;
  logic [b2da_pkg::DIGIT_W-1:0] digits [b2da_pkg::MAX_DIGITS];

  assign ctl = b2da_pkg::ctl_rom(pc);
  assign busy = ctl.busy;
  assign load_go = ctl.load & start;

  always_comb begin
    case (ctl.cond)
      b2da_pkg::COND_START: cond_hit = start;
      b2da_pkg::COND_QZERO: cond_hit = (quo == '0);
      b2da_pkg::COND_LAST:  cond_hit = (cnt == b2da_pkg::CNT_W'(1));
      default:              cond_hit = 1'b0;
    endcase
  end

  assign pc_next = cond_hit ? ctl.tgt_t : ctl.tgt_f;

  assign mult_a = ctl.load ? value : {{(b2da_pkg::VALUE_W - b2da_pkg::QUO_W){1'b0}}, quo};
  assign product = {{(b2da_pkg::PROD_W - b2da_pkg::VALUE_W){1'b0}}, mult_a}
                 * {{(b2da_pkg::PROD_W - b2da_pkg::VALUE_W){1'b0}}, b2da_pkg::RECIP_TEN};

  // remainder is below ten, so the low four bits of dividend - 10*q suffice
  assign ten_q = {quo[0], 3'b000} + {quo[2:0], 1'b0};
  assign rem = dividend - ten_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= b2da_pkg::STEP_IDLE;
      cnt         <= '0;
      digit_valid <= 1'b0;
    end else begin
      pc          <= pc_next;
      digit_valid <= ctl.emit;
      if (load_go) begin
        cnt <= '0;
      end else if (ctl.div) begin
        cnt <= cnt + b2da_pkg::CNT_W'(1);
      end else if (ctl.emit) begin
        cnt <= cnt - b2da_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_go || ctl.div) begin
      quo      <= product[b2da_pkg::PROD_W-1:b2da_pkg::QUO_SHIFT];
      dividend <= mult_a[b2da_pkg::DIGIT_W-1:0];
    end
    if (ctl.div) begin
      digits[cnt] <= rem;
    end
    if (ctl.emit) begin
      digit_char <= b2da_pkg::ASCII_ZERO
                  + {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}},
                     digits[cnt - b2da_pkg::CNT_W'(1)]};
      last       <= (cnt == b2da_pkg::CNT_W'(1));
    end
  end

  `B2DA_ASSERT_NOW(a_char_range, digit_valid, (digit_char >= b2da_pkg::ASCII_ZERO) && (digit_char <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(9)), "digit_char outside 0..9")
  `B2DA_ASSERT_NOW(a_last_idle, digit_valid && last, !busy, "sequencer not idle after last digit")
  `B2DA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
  `B2DA_ASSERT_NOW(a_div_room, pc == b2da_pkg::STEP_DIV, cnt < b2da_pkg::CNT_W'(b2da_pkg::MAX_DIGITS), "digit buffer overrun")
  `B2DA_ASSERT_NOW(a_emit_cnt, pc == b2da_pkg::STEP_EMIT, cnt != '0, "emit with empty digit buffer")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PER_PHASE = 67;
  localparam int NUM_DIRECTED = 20;

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } digit_t;

  typedef struct {
    logic [b2da_pkg::VALUE_W-1:0] value;
    string                        text;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [b2da_pkg::VALUE_W-1:0]  value = '0;
  logic                          busy;
  logic                          digit_valid;
  logic [b2da_pkg::CHAR_W-1:0]   digit_char;
  logic                          last;

  digit_t pending_digits[$];
  int     errors = 0;
  int     quiet_cycles = 0;

  // empty text: expectation comes from the predictor
  row_t directed_rows[NUM_DIRECTED] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'd100,        "100"},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{32'hFFFFFFFF,   "4294967295"},
    '{32'hFFFFFFFE,   "4294967294"},
    '{32'd0,          "0"},
    '{32'h80000000,   ""},
    '{32'h7FFFFFFF,   ""},
    '{32'h55555555,   ""},
    '{32'hAAAAAAAA,   ""},
    '{32'h0000FFFF,   ""},
    '{32'hFFFF0000,   ""},
    '{32'd65536,      ""},
    '{32'd123456789,  ""},
    '{32'd12345,      ""},
    '{32'd99,         ""}
  };

  binary_to_decimal_ascii_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .value       (value),
    .busy        (busy),
    .digit_valid (digit_valid),
    .digit_char  (digit_char),
    .last        (last)
  );

  always #10 clk = ~clk;

  function automatic void predict_digits(input logic [b2da_pkg::VALUE_W-1:0] n);
    logic [3:0]                   rev [b2da_pkg::MAX_DIGITS];
    logic [b2da_pkg::VALUE_W-1:0] rest;
    int                           count;
    digit_t                       d;
    rest = n;
    count = 0;
    do begin
      rev[count] = 4'(rest % 10);
      rest = rest / 10;
      count++;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      d.ch = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rev[k]);
      d.last = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  // digit count spread evenly, some plain 32-bit values
  function automatic logic [b2da_pkg::VALUE_W-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    int              ndig;
    lo = 1;
    if ($urandom_range(9) == 0) return $urandom;
    ndig = $urandom_range(1, b2da_pkg::MAX_DIGITS);
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'hFFFFFFFF) hi = 64'hFFFFFFFF;
    if (ndig == 1) lo = 0;
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic send_request(input logic [b2da_pkg::VALUE_W-1:0] v, input string text,
                              input int idle_pct);
    digit_t d;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (text.len() == 0) begin
      predict_digits(v);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        d.ch = b2da_pkg::CHAR_W'(text[i]);
        d.last = (i == text.len() - 1);
        pending_digits.push_back(d);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_digits.size() != 0);
  endtask

  always @(posedge clk) begin
    digit_t want;
    if (!rst && digit_valid) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit 0x%0h last %0b", digit_char, last));
      end else begin
        want = pending_digits.pop_front();
        if (digit_char !== want.ch)
          report_mismatch($sformatf("digit_char 0x%0h, want 0x%0h", digit_char, want.ch));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || digit_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int idle_pct [3];
    idle_pct = '{33, 52, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_request(directed_rows[i].value, directed_rows[i].text, idle_pct[0]);
    drain();
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        send_request(random_value(), "", idle_pct[p]);
      drain();
    end
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
